/* rtl/core/grzp_pkg.sv */
// Shared types and constants for the ground ray zone picker.
package grzp_pkg;

    localparam int COORD_W    = 32;
    localparam int DIR_W      = 16;
    localparam int ID_W       = 16;
    localparam int DELTA_W    = COORD_W + 1;        // plane_height - origin_y
    localparam int PROD_W     = 48;                 // |delta * dir| < 2^48
    localparam int HIT_W      = PROD_W + 2;         // origin + signed quotient
    localparam int DIV_CYCLES = PROD_W / 2;         // two quotient bits per cycle
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DIR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic [ID_W-1:0]    ident;
        logic [COORD_W-1:0] hi_z;
        logic [COORD_W-1:0] lo_z;
        logic [COORD_W-1:0] hi_x;
        logic [COORD_W-1:0] lo_x;
    } t_zone;

endpackage

/* rtl/core/grzp_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port.
module grzp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/grzp_div.sv */
// Unsigned restoring divider, two quotient bits per cycle.
module grzp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  grzp_pkg::t_div_req i_req,
    output grzp_pkg::t_div_rsp o_rsp
);

    localparam int PW = grzp_pkg::PROD_W;
    localparam int DW = grzp_pkg::DIR_W;

    logic                             r_busy;
    logic                             r_done;
    logic [grzp_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [DW-1:0]                    r_rem;
    logic [DW-1:0]                    r_dvs;
    logic [PW-1:0]                    r_q;

    logic [DW:0]   t1, t2, r1, r2;
    logic          ge1, ge2;
    logic [PW-1:0] q1, n_q;
    logic [DW-1:0] n_rem;

    // remainder stays below the divisor, so the shifted value fits DW+1 bits
    always_comb begin
        t1    = {r_rem, r_q[PW-1]};
        ge1   = t1 >= {1'b0, r_dvs};
        r1    = ge1 ? (t1 - {1'b0, r_dvs}) : t1;
        q1    = {r_q[PW-2:0], ge1};
        t2    = {r1[DW-1:0], q1[PW-1]};
        ge2   = t2 >= {1'b0, r_dvs};
        r2    = ge2 ? (t2 - {1'b0, r_dvs}) : t2;
        n_q   = {q1[PW-2:0], ge2};
        n_rem = r2[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == grzp_pkg::DIV_CNT_W'(grzp_pkg::DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

/* rtl/core/ground_ray_zone_pick_top.sv */
// Ground ray picker top: zone table, ray/plane intersect sequencer, APB register.
// Clear/append words are taken in idle. A plane miss goes straight to output. A plane hit
// runs two passes (x, then z), each a multiply, a divider start, a serial divide and an
// add, then a zone scan that stops on the first match, then output.
// One word in flight: no new word is taken until the query result enters the output register.
// Sync active-low reset clears zone count, plane height and control; zone table kept.
module ground_ray_zone_pick_top #(
    parameter int MAX_ZONES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // stream in
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // min_x[31:0] max_x[63:32] min_z[95:64] max_z[127:96] zone_ident[143:128]
    // origin_x[175:144] origin_y[207:176] origin_z[239:208]
    // dir_x[255:240] dir_y[271:256] dir_z[287:272]
    input  logic [287:0] i_s_axis_tdata,
    input  logic [1:0]   i_s_axis_tuser,   // kind[1:0]
    // stream out
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [79:0]  o_m_axis_tdata,   // found_ident[15:0] hit_x[47:16] hit_z[79:48]
    output logic [1:0]   o_m_axis_tuser,   // plane_hit[0] zone_found[1]
    // APB config
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CW = $clog2(MAX_ZONES + 1);
    localparam int CRW = grzp_pkg::COORD_W;
    localparam int DRW = grzp_pkg::DIR_W;
    localparam int HW = grzp_pkg::HIT_W;
    localparam int PW = grzp_pkg::PROD_W;
    localparam int ZW = $bits(grzp_pkg::t_zone);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DGO  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    function automatic logic [CRW-1:0] sat_coord(input logic signed [HW-1:0] v);
        logic signed [HW-1:0] vmax;
        logic signed [HW-1:0] vmin;
        vmax = {{(HW-CRW+1){1'b0}}, {(CRW-1){1'b1}}};
        vmin = {{(HW-CRW+1){1'b1}}, {(CRW-1){1'b0}}};
        if (v > vmax) begin
            sat_coord = vmax[CRW-1:0];
        end else if (v < vmin) begin
            sat_coord = vmin[CRW-1:0];
        end else begin
            sat_coord = v[CRW-1:0];
        end
    endfunction

    // input word fields
    logic [1:0]            in_kind;
    grzp_pkg::t_zone       in_zone;
    logic signed [CRW-1:0] in_ox, in_oy, in_oz;
    logic signed [DRW-1:0] in_dx, in_dy, in_dz;

    assign in_kind       = i_s_axis_tuser;
    assign in_zone.lo_x  = i_s_axis_tdata[31:0];
    assign in_zone.hi_x  = i_s_axis_tdata[63:32];
    assign in_zone.lo_z  = i_s_axis_tdata[95:64];
    assign in_zone.hi_z  = i_s_axis_tdata[127:96];
    assign in_zone.ident = i_s_axis_tdata[143:128];
    assign in_ox         = i_s_axis_tdata[175:144];
    assign in_oy         = i_s_axis_tdata[207:176];
    assign in_oz         = i_s_axis_tdata[239:208];
    assign in_dx         = i_s_axis_tdata[255:240];
    assign in_dy         = i_s_axis_tdata[271:256];
    assign in_dz         = i_s_axis_tdata[287:272];

    // control state
    logic [2:0]    r_state;
    logic          r_axis;        // 0: x pass, 1: z pass
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_raddr;
    logic          r_rd_pend;
    logic [CRW-1:0] r_ph;
    logic          r_ovalid;

    // datapath
    logic signed [grzp_pkg::DELTA_W-1:0] r_d;
    logic signed [CRW-1:0] r_ox, r_oz;
    logic signed [DRW-1:0] r_dx, r_dy, r_dz;
    logic [PW-1:0]         r_pmag;
    logic                  r_qneg;
    logic signed [HW-1:0]  r_hx, r_hz;
    logic                  r_hit;
    logic                  r_found;
    logic [grzp_pkg::ID_W-1:0] r_ident;
    logic                  r_o_hit, r_o_found;
    logic [grzp_pkg::ID_W-1:0] r_o_ident;
    logic [CRW-1:0]        r_o_hx, r_o_hz;

    logic in_acc;
    logic cfg_wr;
    logic app_we;
    logic no_hit;
    logic signed [DRW-1:0] mul_dir;
    logic signed [PW:0]    prod;
    logic [PW-1:0]         prod_mag;
    logic [DRW-1:0]        dy_mag;
    logic signed [HW-1:0]  q_signed;
    logic signed [HW-1:0]  h_sum;
    logic                  rd_go;
    logic                  zone_hit;
    logic                  out_load;
    grzp_pkg::t_zone       rd_zone;
    logic [ZW-1:0]         rd_bits;
    grzp_pkg::t_div_req    div_req;
    grzp_pkg::t_div_rsp    div_rsp;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign app_we  = in_acc && (in_kind == grzp_pkg::KIND_APPEND) && (r_count < CW'(MAX_ZONES));
    assign cfg_wr  = psel && penable && pwrite && pready && !paddr[2];
    assign pready  = 1'b1;
    assign prdata  = paddr[2] ? '0 : r_ph;

    // plane behind the origin or parallel to the ray
    assign no_hit = (r_dy == '0) ||
                    (!r_d[grzp_pkg::DELTA_W-1] && (r_d != '0) && r_dy[DRW-1]) ||
                    (r_d[grzp_pkg::DELTA_W-1] && !r_dy[DRW-1]);

    always_comb begin
        mul_dir  = r_axis ? r_dz : r_dx;
        prod     = r_d * mul_dir;
        prod_mag = prod[PW] ? PW'(-prod) : prod[PW-1:0];
        dy_mag   = r_dy[DRW-1] ? DRW'(-r_dy) : r_dy;
        q_signed = r_qneg ? -HW'(div_rsp.quotient) : HW'(div_rsp.quotient);
        h_sum    = (r_axis ? HW'(r_oz) : HW'(r_ox)) + q_signed;
    end

    assign div_req.start    = (r_state == S_DGO);
    assign div_req.dividend = r_pmag;
    assign div_req.divisor  = dy_mag;

    grzp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    grzp_ram #(
        .WIDTH (ZW),
        .DEPTH (MAX_ZONES)
    ) u_zone_ram (
        .i_clk   (i_clk),
        .i_we    (app_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (in_zone),
        .i_raddr (r_raddr[AW-1:0]),
        .o_rdata (rd_bits)
    );

    assign rd_zone = rd_bits;
    assign rd_go   = (r_raddr < r_count);
    assign zone_hit = r_rd_pend &&
                      (r_hx >= HW'(signed'(rd_zone.lo_x))) &&
                      (r_hx <= HW'(signed'(rd_zone.hi_x))) &&
                      (r_hz >= HW'(signed'(rd_zone.lo_z))) &&
                      (r_hz <= HW'(signed'(rd_zone.hi_z)));
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_axis    <= 1'b0;
            r_count   <= '0;
            r_raddr   <= '0;
            r_rd_pend <= 1'b0;
            r_ph      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_ph <= pwdata;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (in_kind == grzp_pkg::KIND_CLEAR) begin
                            r_count <= '0;
                        end else if (app_we) begin
                            r_count <= r_count + 1'b1;
                        end else if (in_kind == grzp_pkg::KIND_QUERY) begin
                            r_axis  <= 1'b0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (!r_axis && no_hit) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DGO;
                    end
                end
                S_DGO: r_state <= S_DIV;
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_raddr   <= '0;
                        r_rd_pend <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_pend <= rd_go;
                    if (rd_go) begin
                        r_raddr <= r_raddr + 1'b1;
                    end
                    if (zone_hit || (!rd_go && !r_rd_pend)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_d  <= grzp_pkg::DELTA_W'(signed'(r_ph)) - grzp_pkg::DELTA_W'(in_oy);
            r_ox <= in_ox;
            r_oz <= in_oz;
            r_dx <= in_dx;
            r_dy <= in_dy;
            r_dz <= in_dz;
        end
        if (r_state == S_MUL) begin
            r_pmag <= prod_mag;
            r_qneg <= prod[PW] ^ r_dy[DRW-1];
            r_hit  <= !no_hit;
            r_found <= 1'b0;
            r_ident <= '0;
        end
        if (r_state == S_ADD) begin
            if (r_axis) begin
                r_hz <= h_sum;
            end else begin
                r_hx <= h_sum;
            end
        end
        if ((r_state == S_SCAN) && zone_hit) begin
            r_found <= 1'b1;
            r_ident <= rd_zone.ident;
        end
        if (out_load) begin
            r_o_hit   <= r_hit;
            r_o_found <= r_found;
            r_o_ident <= r_ident;
            r_o_hx    <= r_hit ? sat_coord(r_hx) : '0;
            r_o_hz    <= r_hit ? sat_coord(r_hz) : '0;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_o_hz, r_o_hx, r_o_ident};
    assign o_m_axis_tuser  = {r_o_found, r_o_hit};

endmodule
